/* rtl/core/i2c_bm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bm_pkg
// Shared types and constants of the bit-level I2C master.
// ----------------------------------------------------------------------------
package i2c_bm_pkg;

  localparam int unsigned DelayW   = 16;
  localparam int unsigned TimeoutW = 10;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [DelayW-1:0]   PhaseDelayRst = 16'd168;
  localparam logic [TimeoutW-1:0] AckTimeoutRst = 10'd250;

  localparam logic [CfgIdxW-1:0] CfgPhaseDelay = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_SP_C    = 5'd5,
    PH_WR_DATA = 5'd6,
    PH_WR_HIGH = 5'd7,
    PH_WR_LOW  = 5'd8,
    PH_AK_REL  = 5'd9,
    PH_AK_HIGH = 5'd10,
    PH_AK_POLL = 5'd11,
    PH_RD_HIGH = 5'd12,
    PH_RD_LOW  = 5'd13,
    PH_RA_SET  = 5'd14,
    PH_RA_HIGH = 5'd15
  } phase_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  typedef struct packed {
    phase_e              phase;
    logic [3:0]          bit_idx;
    logic [7:0]          shift_byte;
    logic [DelayW-1:0]   delay_cnt;
    logic [TimeoutW-1:0] ack_wait_cnt;
    logic                scl_level;
    logic                sda_level;
    logic                err_flag;
    logic [7:0]          rx_hold;
    logic                ack_mode;
  } state_t;

  typedef struct packed {
    logic [DelayW-1:0]   phase_delay;
    logic [TimeoutW-1:0] ack_timeout;
  } cfg_t;

endpackage

/* rtl/core/i2c_bm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bm_if
// Tick and result channels of the bit-level I2C master.
// ----------------------------------------------------------------------------
interface i2c_bm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, output operation, output tx_byte, output send_ack,
                  output sda_in, input ready);
  modport sink (input valid, input operation, input tx_byte, input send_ack,
                input sda_in, output ready);
endinterface

interface i2c_bm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rx_byte, output ack_error, input ready);
  modport sink (input valid, input scl_out, input sda_out, input busy_res,
                input done_res, input rx_byte, input ack_error, output ready);
endinterface

/* rtl/core/i2c_bm_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bm_cfg
// Configuration registers: phase delay and ack timeout.
// ----------------------------------------------------------------------------
module i2c_bm_cfg
  import i2c_bm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_delay <= PhaseDelayRst;
      cfg_q.ack_timeout <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPhaseDelay: cfg_q.phase_delay <= cfg_wdata_i[DelayW-1:0];
        CfgAckTimeout: cfg_q.ack_timeout <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/i2c_bm_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bm_step
// One tick of the pin sequencer: next state and the pin/status word.
// ----------------------------------------------------------------------------
module i2c_bm_step
  import i2c_bm_pkg::*;
(
  input  state_t state_i,
  input  item_t  item_i,
  input  cfg_t   cfg_i,
  output state_t state_o,
  output res_t   res_o
);

  state_t            s;
  logic              done;
  logic [DelayW-1:0] dly;
  logic [3:0]        bit_nx;

  // a zero delay is replaced by a delay value of one
  assign dly    = (cfg_i.phase_delay == '0) ? {{(DelayW-1){1'b0}}, 1'b1} : cfg_i.phase_delay;
  assign bit_nx = state_i.bit_idx + 4'd1;

  always_comb begin
    s    = state_i;
    done = 1'b0;
    if (state_i.phase == PH_IDLE) begin
      case (op_e'(item_i.operation))
        OP_START: begin
          s.sda_level = 1'b1;
          s.scl_level = 1'b1;
          s.phase     = PH_ST_A;
          s.delay_cnt = dly;
        end
        OP_STOP: begin
          s.scl_level = 1'b0;
          s.sda_level = 1'b0;
          s.phase     = PH_SP_A;
          s.delay_cnt = dly;
        end
        OP_WRITE: begin
          s.err_flag     = 1'b0;
          s.ack_wait_cnt = '0;
          s.bit_idx      = '0;
          s.scl_level    = 1'b0;
          s.sda_level    = item_i.tx_byte[7];
          s.shift_byte   = {item_i.tx_byte[6:0], 1'b0};
          s.phase        = PH_WR_DATA;
          s.delay_cnt    = dly;
        end
        OP_READ: begin
          s.ack_mode   = item_i.send_ack;
          s.bit_idx    = '0;
          s.shift_byte = '0;
          s.sda_level  = 1'b1;
          s.scl_level  = 1'b1;
          s.phase      = PH_RD_HIGH;
          s.delay_cnt  = dly;
        end
        default: ;
      endcase
    end else if (state_i.phase != PH_AK_POLL && state_i.delay_cnt > {{(DelayW-1){1'b0}}, 1'b1})
    begin
      s.delay_cnt = state_i.delay_cnt - {{(DelayW-1){1'b0}}, 1'b1};
    end else begin
      case (state_i.phase)
        PH_ST_A: begin
          s.sda_level = 1'b0;
          s.phase     = PH_ST_B;
          s.delay_cnt = dly;
        end
        PH_ST_B: begin
          s.scl_level = 1'b0;
          s.phase     = PH_IDLE;
          done        = 1'b1;
        end
        PH_SP_A: begin
          s.scl_level = 1'b1;
          s.phase     = PH_SP_B;
          s.delay_cnt = dly;
        end
        PH_SP_B: begin
          s.sda_level = 1'b1;
          s.phase     = PH_SP_C;
          s.delay_cnt = dly;
        end
        PH_SP_C: begin
          s.phase = PH_IDLE;
          done    = 1'b1;
        end
        PH_WR_DATA: begin
          s.scl_level = 1'b1;
          s.phase     = PH_WR_HIGH;
          s.delay_cnt = dly;
        end
        PH_WR_HIGH: begin
          s.scl_level = 1'b0;
          s.phase     = PH_WR_LOW;
          s.delay_cnt = dly;
        end
        PH_WR_LOW: begin
          s.bit_idx   = bit_nx;
          s.delay_cnt = dly;
          if (bit_nx < 4'd8) begin
            s.sda_level  = state_i.shift_byte[7];
            s.shift_byte = {state_i.shift_byte[6:0], 1'b0};
            s.phase      = PH_WR_DATA;
          end else begin
            // release SDA for the slave ack
            s.sda_level = 1'b1;
            s.phase     = PH_AK_REL;
          end
        end
        PH_AK_REL: begin
          s.scl_level = 1'b1;
          s.phase     = PH_AK_HIGH;
          s.delay_cnt = dly;
        end
        PH_AK_HIGH, PH_AK_POLL: begin
          if (!item_i.sda_in) begin
            s.scl_level = 1'b0;
            s.phase     = PH_IDLE;
            done        = 1'b1;
          end else if (state_i.ack_wait_cnt >= cfg_i.ack_timeout) begin
            // no ack: flag and drop into a stop sequence
            s.err_flag  = 1'b1;
            s.scl_level = 1'b0;
            s.sda_level = 1'b0;
            s.phase     = PH_SP_A;
            s.delay_cnt = dly;
          end else begin
            s.ack_wait_cnt = state_i.ack_wait_cnt + {{(TimeoutW-1){1'b0}}, 1'b1};
            s.phase        = PH_AK_POLL;
            s.delay_cnt    = '0;
          end
        end
        PH_RD_HIGH: begin
          s.shift_byte = {state_i.shift_byte[6:0], item_i.sda_in};
          s.scl_level  = 1'b0;
          s.phase      = PH_RD_LOW;
          s.delay_cnt  = dly;
        end
        PH_RD_LOW: begin
          s.bit_idx   = bit_nx;
          s.delay_cnt = dly;
          if (bit_nx < 4'd8) begin
            s.scl_level = 1'b1;
            s.phase     = PH_RD_HIGH;
          end else begin
            s.rx_hold   = state_i.shift_byte;
            s.scl_level = 1'b0;
            s.sda_level = !state_i.ack_mode;
            s.phase     = PH_RA_SET;
          end
        end
        PH_RA_SET: begin
          s.scl_level = 1'b1;
          s.phase     = PH_RA_HIGH;
          s.delay_cnt = dly;
        end
        PH_RA_HIGH: begin
          s.scl_level = 1'b0;
          s.phase     = PH_IDLE;
          done        = 1'b1;
        end
        default: begin
          s.phase = PH_IDLE;
        end
      endcase
    end
  end

  assign state_o         = s;
  assign res_o.scl_out   = s.scl_level;
  assign res_o.sda_out   = s.sda_level;
  assign res_o.busy_res  = (s.phase != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.rx_byte   = s.rx_hold;
  assign res_o.ack_error = s.err_flag;

endmodule

/* rtl/core/i2c_bit_level_master_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// Pin-level I2C master: one word in per clock tick, one pin/status word out.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one tick: an optional command (start, stop, write, read),
//   the byte to send, the ack choice for a read and the sampled SDA level.
//   out_if returns, for every tick, the SCL/SDA drive levels, busy, a done
//   pulse, the last read byte and the ack error flag.
//   Commands are taken only while the sequencer is idle; others are dropped.
//   An accepted word is held in the input register, run through the
//   sequencer logic and then registered in the output register.
//   Throughput: one word per cycle while out_if.ready stays high, set by the
//   single step from the input register to the output register; the input
//   register accepts a new word whenever the output register is free or is being emptied.
//   If the receiver stalls, both registers hold and ready drops once full.
//   Reset puts SCL and SDA released, the sequencer idle, status cleared and
//   the configuration at its defaults. Configuration writes take effect at
//   once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top
  import i2c_bm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  i2c_bm_in_if.sink           in_if,
  i2c_bm_out_if.source        out_if
);

  cfg_t   cfg;
  item_t  in_q;
  logic   in_vld_q;
  state_t st_q, st_d;
  res_t   res_d, out_q;
  logic   out_vld_q;
  logic   step_go;
  logic   in_rdy;

  i2c_bm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  i2c_bm_step u_step (
    .state_i(st_q),
    .item_i (in_q),
    .cfg_i  (cfg),
    .state_o(st_d),
    .res_o  (res_d)
  );

  // advance the registered word whenever the output register can take it
  assign step_go = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_rdy  = !in_vld_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_if.valid) begin
      in_q.operation <= in_if.operation;
      in_q.tx_byte   <= in_if.tx_byte;
      in_q.send_ack  <= in_if.send_ack;
      in_q.sda_in    <= in_if.sda_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase        <= PH_IDLE;
      st_q.bit_idx      <= '0;
      st_q.shift_byte   <= '0;
      st_q.delay_cnt    <= '0;
      st_q.ack_wait_cnt <= '0;
      st_q.scl_level    <= 1'b1;
      st_q.sda_level    <= 1'b1;
      st_q.err_flag     <= 1'b0;
      st_q.rx_hold      <= '0;
      st_q.ack_mode     <= 1'b0;
    end else if (step_go) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_go) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      out_q <= res_d;
    end
  end

  assign in_if.ready      = in_rdy;
  assign out_if.valid     = out_vld_q;
  assign out_if.scl_out   = out_q.scl_out;
  assign out_if.sda_out   = out_q.sda_out;
  assign out_if.busy_res  = out_q.busy_res;
  assign out_if.done_res  = out_q.done_res;
  assign out_if.rx_byte   = out_q.rx_byte;
  assign out_if.ack_error = out_q.ack_error;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done word reports busy");

  a_busy_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> out_q.busy_res == (st_q.phase != PH_IDLE))
    else $error("busy flag out of step with sequencer phase");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_rdy)
    else $error("input stalled while output register empty");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> out_vld_q)
    else $error("stepped word lost");
`endif

endmodule
